// ===== rtl/fpba_pkg.sv =====
package fpba_pkg;

  localparam int unsigned SlotW   = 4;
  localparam int unsigned AmountW = 16;
  localparam int unsigned RemW    = 16;
  localparam int unsigned PolW    = 2;
  localparam int unsigned NbW     = 5;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 5;

  localparam logic [CfgIdxW-1:0] CfgPolicy    = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgNumBlocks = 1'd1;

  localparam logic [PolW-1:0] PolFirst = 2'd0;
  localparam logic [PolW-1:0] PolBest  = 2'd1;
  localparam logic [PolW-1:0] PolWorst = 2'd2;

  localparam logic OpLoad    = 1'b0;
  localparam logic OpRequest = 1'b1;

  localparam logic [NbW-1:0] NumBlocksReset = 5'd16;

  typedef struct packed {
    logic               op;
    logic [SlotW-1:0]   slot;
    logic [AmountW-1:0] amount;
    logic               last_request;
  } alloc_in_t;

  typedef struct packed {
    logic             granted;
    logic [SlotW-1:0] block_index;
    logic [RemW-1:0]  remaining;
    logic             batch_end;
  } alloc_out_t;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDrain,
    StWb,
    StDone
  } state_e;

endpackage

// ===== rtl/fit_policy_block_allocator.sv =====
// Block allocator with first, best and worst fit placement.
// Input channel (in_valid_i / in_stall_o) carries load and request items; the
// output channel (out_valid_o / out_stall_i) returns exactly one result per item.
// A load writes one block's capacity and goes straight to the done state. A
// request scans the capacity table one block per cycle through its single read
// port, over the first limit blocks, where limit is min(num_blocks, NUM_BLOCKS,
// 31), then passes the drain and write-back states; a request with a limit of
// zero goes straight to the done state. The result enters the output register at
// the edge at which the item leaves the sequencer, held back while it is full.
// The configuration port (cfg_we_i, cfg_idx_i, cfg_data_i) writes policy and
// num_blocks; the user uses it only while idle, which the block does not enforce.
// Reset clears all capacities to zero through per-block valid bits, sets policy
// to first fit and num_blocks to 16, and empties the output register.
// While the receiver stalls, the finished result holds in the output register;
// the block still accepts one more item and parks its result until the
// register drains.
module fit_policy_block_allocator #(
  parameter int unsigned NUM_BLOCKS = 16,
  parameter int unsigned SIZE_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  fpba_pkg::alloc_in_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output fpba_pkg::alloc_out_t                out_data_o,
  input  logic                                cfg_we_i,
  input  logic [fpba_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [fpba_pkg::CfgW-1:0]           cfg_data_i
);
  import fpba_pkg::*;

  localparam int unsigned IdxW   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CmpW   = (SIZE_WIDTH > AmountW) ? SIZE_WIDTH : AmountW;
  localparam int unsigned LimMax = (NUM_BLOCKS > 31) ? 31 : NUM_BLOCKS;

  logic [SIZE_WIDTH-1:0] mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] vld_q, vld_d;
  logic [SIZE_WIDTH-1:0] rd_data_q;
  logic                  rd_vld_q;
  logic [IdxW-1:0]       rd_addr;
  logic                  wr_en;
  logic [IdxW-1:0]       wr_addr;
  logic [SIZE_WIDTH-1:0] wr_data;

  state_e           state_q, state_d;
  logic [PolW-1:0]  policy_q, policy_d;
  logic [NbW-1:0]   num_blocks_q, num_blocks_d;
  logic [NbW-1:0]   lim_q, lim_d;
  logic [NbW-1:0]   lim_cfg;
  logic [NbW-1:0]   iss_q, iss_d;
  logic             pend_q, pend_d;
  logic [NbW-1:0]   pend_idx_q, pend_idx_d;
  logic             found_q, found_d;
  logic [NbW-1:0]   pick_q, pick_d;
  logic [SIZE_WIDTH-1:0] best_cap_q, best_cap_d;
  logic [AmountW-1:0]    amount_q, amount_d;
  logic                  last_q, last_d;
  alloc_out_t       res_q, res_d;
  logic             out_valid_q, out_valid_d;
  alloc_out_t       out_q, out_d;

  logic                  in_xfer;
  logic                  cap_fits;
  logic                  take;
  logic [SIZE_WIDTH-1:0] cur_cap;
  logic [SIZE_WIDTH-1:0] new_cap;

  assign in_stall_o  = (state_q != StIdle);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign lim_cfg     = (num_blocks_q > NbW'(LimMax)) ? NbW'(LimMax) : num_blocks_q;
  assign rd_addr     = IdxW'(iss_q);
  assign cur_cap     = rd_vld_q ? rd_data_q : '0;
  assign cap_fits    = CmpW'(cur_cap) >= CmpW'(amount_q);
  assign new_cap     = best_cap_q - SIZE_WIDTH'(amount_q);

  always_comb begin
    case (policy_q)
      PolBest:  take = !found_q || (cur_cap < best_cap_q);
      PolWorst: take = !found_q || (cur_cap > best_cap_q);
      default:  take = !found_q;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    policy_d     = policy_q;
    num_blocks_d = num_blocks_q;
    lim_d        = lim_q;
    iss_d        = iss_q;
    pend_d       = 1'b0;
    pend_idx_d   = iss_q;
    found_d      = found_q;
    pick_d       = pick_q;
    best_cap_d   = best_cap_q;
    amount_d     = amount_q;
    last_d       = last_q;
    res_d        = res_q;
    vld_d        = vld_q;
    wr_en        = 1'b0;
    wr_addr      = IdxW'(in_data_i.slot);
    wr_data      = SIZE_WIDTH'(in_data_i.amount);
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPolicy:    policy_d = cfg_data_i[PolW-1:0];
        CfgNumBlocks: num_blocks_d = cfg_data_i[NbW-1:0];
        default:      ;
      endcase
    end

    if (pend_q && cap_fits && take) begin
      found_d    = 1'b1;
      pick_d     = pend_idx_q;
      best_cap_d = cur_cap;
    end

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          amount_d = in_data_i.amount;
          last_d   = in_data_i.last_request;
          res_d    = '{granted: 1'b0, block_index: '0, remaining: '0,
                       batch_end: in_data_i.last_request};
          state_d  = StDone;
          if (in_data_i.op == OpLoad) begin
            if (32'(in_data_i.slot) < NUM_BLOCKS) begin
              wr_en          = 1'b1;
              vld_d[wr_addr] = 1'b1;
              res_d.granted     = 1'b1;
              res_d.block_index = in_data_i.slot;
              res_d.remaining   = RemW'(wr_data);
            end
          end else begin
            found_d = 1'b0;
            pick_d  = '0;
            iss_d   = '0;
            lim_d   = lim_cfg;
            if (lim_cfg != '0) begin
              state_d = StScan;
            end
          end
        end
      end
      StScan: begin
        pend_d     = 1'b1;
        pend_idx_d = iss_q;
        iss_d      = iss_q + NbW'(1);
        if (iss_q == lim_q - NbW'(1)) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StWb;
      end
      StWb: begin
        res_d = '{granted: 1'b0, block_index: '0, remaining: '0, batch_end: last_q};
        if (found_q) begin
          wr_en          = 1'b1;
          wr_addr        = IdxW'(pick_q);
          wr_data        = new_cap;
          vld_d[wr_addr] = 1'b1;
          res_d.granted     = 1'b1;
          res_d.block_index = pick_q[SlotW-1:0];
          res_d.remaining   = RemW'(new_cap);
        end
        state_d = StDone;
      end
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      policy_q     <= PolFirst;
      num_blocks_q <= NumBlocksReset;
      vld_q        <= '0;
      out_valid_q  <= 1'b0;
      pend_q       <= 1'b0;
      found_q      <= 1'b0;
      iss_q        <= '0;
      lim_q        <= '0;
      pick_q       <= '0;
    end else begin
      state_q      <= state_d;
      policy_q     <= policy_d;
      num_blocks_q <= num_blocks_d;
      vld_q        <= vld_d;
      out_valid_q  <= out_valid_d;
      pend_q       <= pend_d;
      found_q      <= found_d;
      iss_q        <= iss_d;
      lim_q        <= lim_d;
      pick_q       <= pick_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    best_cap_q <= best_cap_d;
    amount_q   <= amount_d;
    last_q     <= last_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
    rd_vld_q  <= vld_q[rd_addr];
  end

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScan |-> iss_q < lim_q)
    else $error("scan index ran past the block limit");

  a_pick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StWb && found_q |-> pick_q < lim_q)
    else $error("chosen block lies outside the scanned range");

  a_pick_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StWb && found_q |-> CmpW'(best_cap_q) >= CmpW'(amount_q))
    else $error("chosen block cannot hold the request");

  a_accept_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == StScan || state_q == StDone)
    else $error("accepted transfer did not start a scan or finish");

  a_done_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDone && !out_valid_q |=> out_valid_q && state_q == StIdle)
    else $error("finished result was not moved to the output register");

endmodule
